/* hdl/iidl_pkg.sv */
// Shared types and constants for the indexed insert/delete list.
package iidl_pkg;

  localparam int WORD_W  = 32;
  localparam int IDX_W   = 8;
  localparam int CNT_OUT_W = 9;
  localparam int GRP     = 16;  // cells per read-gather group

  typedef enum logic [2:0] {
    RQ_APPEND      = 3'd0,
    RQ_PUSH_FRONT  = 3'd1,
    RQ_INSERT_AT   = 3'd2,
    RQ_REMOVE_AT   = 3'd3,
    RQ_REMOVE_FRONT = 3'd4,
    RQ_REMOVE_BACK = 3'd5,
    RQ_READ        = 3'd6,
    RQ_WRITE       = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    C_HOLD  = 2'd0,
    C_WRITE = 2'd1,
    C_INS   = 2'd2,
    C_DEL   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [WORD_W-1:0]  value;
  } cell_ctrl_t;

endpackage

/* hdl/iidl_if.sv */
// Request and response channel interfaces for the indexed insert/delete list.
interface iidl_req_if;
  import iidl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               req_type;
  logic [IDX_W-1:0]         index;
  logic signed [WORD_W-1:0] value;
  modport source (output valid, req_type, index, value, input ready);
  modport sink (input valid, req_type, index, value, output ready);
endinterface

interface iidl_rsp_if;
  import iidl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] read_value;
  logic [CNT_OUT_W-1:0]     entry_count;
  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink (input valid, status, read_value, entry_count, output ready);
endinterface

/* hdl/indexed_insert_delete_list.sv */
// Top level of the indexed insert/delete list: control, cell row and read gather.
//
// Usage:
//   req (sink): one item per list operation, fields req_type, index, value.
//     Operations: push back/front, insert at, remove at/front/back, read, write.
//   rsp (source): one item per request with status, read_value (zero unless
//     an accepted read) and entry_count after the operation.
// Storage is a row of DEPTH cells; insert shifts the cells above the slot up and
// remove shifts cells at and above it down, each taking its neighbor's word.
// Timing: a request is taken in IDLE, the cell row updates in EXEC while
// each group of 16 cells ORs out its read hit into a register, and in FIN
// the group words are ORed into the response register, which makes the
// response valid. Requests are taken only in IDLE, so a new one waits until
// the last has passed EXEC and FIN. The response register parts the two sides:
// the next request is accepted while a response still waits. If the receiver
// stalls, FIN holds until the response register is free and no request is taken.
// Reset (rst, synchronous) empties the list and drops any pending response;
// cell contents are not cleared, as entries at or above the count are never
// observed.
module indexed_insert_delete_list import iidl_pkg::*; #(
  parameter int DEPTH = 256
) (
  input logic       clk,
  input logic       rst,
  iidl_req_if.sink  req,
  iidl_rsp_if.source rsp
);

  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_t;

  state_t                   state;
  req_t                     rq_type;
  logic [IDX_W-1:0]         rq_index;
  logic signed [WORD_W-1:0] rq_value;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  status_t                  status_next;
  status_t                  fin_status;
  logic                     fin_rd_ok;

  logic                     out_valid;
  status_t                  out_status;
  logic signed [WORD_W-1:0] out_rd;
  logic [CNT_OUT_W-1:0]     out_cnt;
  logic                     load_out;

  cell_ctrl_t               ctrl;
  logic [POS_W-1:0]         pos;
  logic signed [WORD_W-1:0] words [DEPTH];
  logic signed [WORD_W-1:0] rd_words [DEPTH];
  logic signed [WORD_W-1:0] grp_or [NGRP];
  logic signed [WORD_W-1:0] grp_word [NGRP];
  logic signed [WORD_W-1:0] gather;

  logic [CMP_W-1:0]         idx_c;
  logic [CMP_W-1:0]         cnt_c;
  logic                     full;
  logic                     empty;

  assign idx_c = CMP_W'(rq_index);
  assign cnt_c = CMP_W'(count);
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // FIN loads the response register once it is empty or being drained.
  assign load_out = (state == S_FIN) && (!out_valid || rsp.ready);

  // Request decode: status, new count and the command broadcast to the cells.
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    ctrl.op     = C_HOLD;
    ctrl.value  = rq_value;
    pos         = idx_c[POS_W-1:0];
    unique case (rq_type)
      RQ_APPEND: begin
        pos = count[POS_W-1:0];
        if (full) status_next = ST_FULL;
        else begin
          ctrl.op    = C_WRITE;
          count_next = count + 1'b1;
        end
      end
      RQ_PUSH_FRONT: begin
        pos = '0;
        if (full) status_next = ST_FULL;
        else begin
          ctrl.op    = C_INS;
          count_next = count + 1'b1;
        end
      end
      RQ_INSERT_AT: begin
        // range is checked before fullness
        if (idx_c > cnt_c) status_next = ST_RANGE;
        else if (full) status_next = ST_FULL;
        else begin
          ctrl.op    = C_INS;
          count_next = count + 1'b1;
        end
      end
      RQ_REMOVE_AT: begin
        if (empty) status_next = ST_EMPTY;
        else if (idx_c >= cnt_c) status_next = ST_RANGE;
        else begin
          ctrl.op    = C_DEL;
          count_next = count - 1'b1;
        end
      end
      RQ_REMOVE_FRONT: begin
        pos = '0;
        if (empty) status_next = ST_EMPTY;
        else begin
          ctrl.op    = C_DEL;
          count_next = count - 1'b1;
        end
      end
      RQ_REMOVE_BACK: begin
        // the vacated slot lies beyond the count and is never read
        if (empty) status_next = ST_EMPTY;
        else count_next = count - 1'b1;
      end
      RQ_READ: begin
        if (idx_c >= cnt_c) status_next = ST_RANGE;
      end
      RQ_WRITE: begin
        if (idx_c >= cnt_c) status_next = ST_RANGE;
        else ctrl.op = C_WRITE;
      end
      default: status_next = ST_OK;
    endcase
    if (state != S_EXEC) ctrl.op = C_HOLD;
  end

  // Row of cells; ends see zero neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    iidl_cell #(
      .POS_W (POS_W),
      .POS   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .rd_index   (rq_index),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .rd_word    (rd_words[i])
    );
  end

  // First gather level: OR within each group of cells.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) grp_or[g] = grp_or[g] | rd_words[g * GRP + k];
      end
    end
  end

  // Second gather level over the registered group words.
  always_comb begin
    gather = '0;
    for (int g = 0; g < NGRP; g++) gather = gather | grp_word[g];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            rq_type  <= req_t'(req.req_type);
            rq_index <= req.index;
            rq_value <= req.value;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          count      <= count_next;
          fin_status <= status_next;
          fin_rd_ok  <= (rq_type == RQ_READ) && (status_next == ST_OK);
          for (int g = 0; g < NGRP; g++) grp_word[g] <= grp_or[g];
          state      <= S_FIN;
        end
        S_FIN: begin
          if (load_out) begin
            out_status <= fin_status;
            out_rd     <= fin_rd_ok ? gather : '0;
            out_cnt    <= CNT_OUT_W'(count);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_rd;
  assign rsp.entry_count = out_cnt;

  // The count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // The count moves only while a request executes.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    state != S_EXEC |=> $stable(count))
    else $error("entry count changed outside execute");

  // One request moves the count by at most one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> (count == $past(count) || count == $past(count) + 1'b1 ||
                         count == $past(count) - 1'b1))
    else $error("entry count jumped");

  // Rejected requests report a zero read word.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_rd == '0)
    else $error("rejected response carries data");

endmodule

/* hdl/iidl_cell.sv */
// One list slot: holds a word and shifts with its neighbors on insert/delete.
module iidl_cell import iidl_pkg::*; #(
  parameter int POS_W = 8,
  parameter int POS   = 0
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [POS_W-1:0]         pos,
  input  logic [IDX_W-1:0]         rd_index,
  input  logic signed [WORD_W-1:0] left_word,
  input  logic signed [WORD_W-1:0] right_word,
  output logic signed [WORD_W-1:0] word,
  output logic signed [WORD_W-1:0] rd_word
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);
  localparam bit REACH = (POS < (1 << IDX_W));

  logic signed [WORD_W-1:0] word_next;
  logic                     hit;

  always_comb begin
    case (ctrl.op)
      C_WRITE: word_next = (MY_POS == pos) ? ctrl.value : word;
      C_INS: begin
        if (MY_POS > pos) word_next = left_word;
        else if (MY_POS == pos) word_next = ctrl.value;
        else word_next = word;
      end
      C_DEL:   word_next = (MY_POS >= pos) ? right_word : word;
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // this cell's share of the read gather
  assign hit     = REACH && (rd_index == IDX_W'(POS));
  assign rd_word = hit ? word : '0;

endmodule

/* sim/tb.sv */
// Self-checking testbench for the indexed insert/delete list.
module tb;
  import iidl_pkg::*;

  localparam int DEPTH = 256;
  localparam int RANDOM_ITEMS = 1000;

  // Quiet cycles waited at the end, after the last expected response, to
  // catch a stray response.
  localparam int DRAIN_CYCLES = 12;

  typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} mix_t;

  // Scoreboard: a word-level copy of the list, advanced once per accepted
  // request, and a FIFO of the responses those requests must produce.
  class list_scoreboard;
    typedef struct {
      status_t                  status;
      logic signed [WORD_W-1:0] read_value;
      logic [CNT_OUT_W-1:0]     entry_count;
    } rsp_t;

    logic signed [WORD_W-1:0] cells [DEPTH];
    int unsigned n;
    rsp_t pending [$];
    int errors;
    int peak;
    int rejects [4];
    int seen [8];

    function new();
      n = 0;
      errors = 0;
      peak = 0;
      foreach (rejects[i]) rejects[i] = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    // shift entries at and above pos up one place, then drop val in
    function void open_at(int unsigned pos, logic signed [WORD_W-1:0] val);
      for (int unsigned i = n; i > pos; i--) cells[i] = cells[i - 1];
      cells[pos] = val;
      n++;
    endfunction

    // close the hole at pos; the freed top cell goes back to zero
    function void close_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < n; i++) cells[i] = cells[i + 1];
      n--;
      cells[n] = '0;
    endfunction

    function void note_request(req_t op, logic [IDX_W-1:0] idx,
                               logic signed [WORD_W-1:0] val);
      rsp_t want;
      want.status = ST_OK;
      want.read_value = '0;
      case (op)
        RQ_APPEND: begin
          if (n >= DEPTH) want.status = ST_FULL;
          else open_at(n, val);
        end
        RQ_PUSH_FRONT: begin
          if (n >= DEPTH) want.status = ST_FULL;
          else open_at(0, val);
        end
        RQ_INSERT_AT: begin
          // position is checked before fullness
          if (idx > n) want.status = ST_RANGE;
          else if (n >= DEPTH) want.status = ST_FULL;
          else open_at(idx, val);
        end
        RQ_REMOVE_AT: begin
          if (n == 0) want.status = ST_EMPTY;
          else if (idx >= n) want.status = ST_RANGE;
          else close_at(idx);
        end
        RQ_REMOVE_FRONT: begin
          if (n == 0) want.status = ST_EMPTY;
          else close_at(0);
        end
        RQ_REMOVE_BACK: begin
          if (n == 0) want.status = ST_EMPTY;
          else close_at(n - 1);
        end
        RQ_READ: begin
          if (idx >= n) want.status = ST_RANGE;
          else want.read_value = cells[idx];
        end
        default: begin
          if (idx >= n) want.status = ST_RANGE;
          else cells[idx] = val;
        end
      endcase
      want.entry_count = n[CNT_OUT_W-1:0];
      seen[op]++;
      rejects[want.status]++;
      if (n > peak) peak = n;
      pending.insert(pending.size(), want);
    endfunction

    function void check_response(logic [1:0] status, logic signed [WORD_W-1:0] rd,
                                 logic [CNT_OUT_W-1:0] cnt);
      rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        $error("response with no request waiting: status %0d count %0d", status, cnt);
        return;
      end
      want = pending.pop_front();
      if (status !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, status);
      end
      if (rd !== want.read_value) begin
        errors++;
        $error("read_value: expected %0d, got %0d", want.read_value, rd);
      end
      if (cnt !== want.entry_count) begin
        errors++;
        $error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  iidl_req_if req ();
  iidl_rsp_if rsp ();

  indexed_insert_delete_list #(.DEPTH(DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  list_scoreboard sb = new();

  int burst_left = 0;
  int random_sent = 0;
  int total_sent = 0;
  int rx_duty = 100;
  int rx_phase = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Both channels are observed at the rising edge only. The predictor runs
  // here, so by the following falling edge the stimulus sees the up-to-date
  // entry count when it picks the next request.
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready)
        sb.note_request(req_t'(req.req_type), req.index, req.value);
      if (rsp.valid && rsp.ready)
        sb.check_response(rsp.status, rsp.read_value, rsp.entry_count);
    end
  end

  // Receiver: each time rx_phase wraps to zero it picks a new readiness duty, so
  // there are long always-ready stretches as well as heavy back-pressure.
  always @(negedge clk) begin
    if (rx_phase == 0) begin
      case ($urandom_range(0, 3))
        0, 1: rx_duty = 100;
        2:    rx_duty = 70;
        default: rx_duty = 30;
      endcase
    end
    rx_phase = (rx_phase + 1) % 40;
    rsp.ready = ($urandom_range(0, 99) < rx_duty);
  end

  // Sender pacing: bursts of back-to-back items separated by idle gaps.
  // Returns at the falling edge where the next item is to be driven.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        req.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
  endtask

  // Present one item and hold it until the block takes it.
  task automatic drive(req_t op, logic [IDX_W-1:0] idx, logic signed [WORD_W-1:0] val);
    req.valid = 1'b1;
    req.req_type = op;
    req.index = idx;
    req.value = val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    total_sent++;
  endtask

  task automatic send(req_t op, logic [IDX_W-1:0] idx, logic signed [WORD_W-1:0] val);
    pace();
    drive(op, idx, val);
  endtask

  // Random request. Fill mode leans on pushes and inserts so the list
  // reaches DEPTH; drain mode leans on removals down to empty. Indices
  // are mostly legal, with the slot at the current count and fully random
  // indices mixed in.
  function automatic void choose(input mix_t mode, output req_t op,
                                 output logic [IDX_W-1:0] idx,
                                 output logic signed [WORD_W-1:0] val);
    int r;
    int hi;
    r = $urandom_range(0, 99);
    op = req_t'($urandom_range(0, 7));
    if (mode == MODE_FILL) begin
      if (r < 35) op = RQ_APPEND;
      else if (r < 55) op = RQ_PUSH_FRONT;
      else if (r < 85) op = RQ_INSERT_AT;
    end else if (mode == MODE_DRAIN) begin
      if (r < 30) op = RQ_REMOVE_BACK;
      else if (r < 50) op = RQ_REMOVE_FRONT;
      else if (r < 80) op = RQ_REMOVE_AT;
    end

    hi = (op == RQ_INSERT_AT) ? int'(sb.n) : int'(sb.n) - 1;
    if (hi > 255) hi = 255;
    r = $urandom_range(0, 9);
    if (r == 0 || hi < 0) idx = IDX_W'($urandom_range(0, 255));
    else if (r == 1) idx = (sb.n > 255) ? 8'd255 : sb.n[IDX_W-1:0];
    else idx = IDX_W'($urandom_range(0, hi));

    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: val = 32'sh7FFFFFFF;
        1: val = 32'sh80000000;
        2: val = 32'sd0;
        default: val = -32'sd1;
      endcase
    end else begin
      val = $urandom;
    end
  endfunction

  initial begin
    req_t op;
    logic [IDX_W-1:0] idx;
    logic signed [WORD_W-1:0] val;
    mix_t mode;
    int step;
    int extra;

    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = RQ_APPEND;
    req.index = '0;
    req.value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every rejection on an empty list first.
    send(RQ_REMOVE_FRONT, 8'd0, 32'sd0);
    send(RQ_REMOVE_BACK, 8'd0, 32'sd0);
    send(RQ_REMOVE_AT, 8'd0, 32'sd0);
    send(RQ_READ, 8'd0, 32'sd0);
    send(RQ_WRITE, 8'd0, 32'sd5);
    send(RQ_INSERT_AT, 8'd1, 32'sd7);
    // Build a short list with extreme words; inserts at front, middle, end.
    send(RQ_INSERT_AT, 8'd0, 32'sh7FFFFFFF);
    send(RQ_APPEND, 8'd0, 32'sh80000000);
    send(RQ_PUSH_FRONT, 8'd255, -32'sd1);
    send(RQ_APPEND, 8'd0, 32'sd0);
    send(RQ_INSERT_AT, 8'd2, 32'sh5A5A5A5A);
    send(RQ_INSERT_AT, 8'd5, 32'sh2468ACE1);
    send(RQ_INSERT_AT, 8'd7, 32'sd1);
    // Reads at both ends and past the end; writes inside the list and past it.
    send(RQ_READ, 8'd0, 32'sd0);
    send(RQ_READ, 8'd5, 32'sd0);
    send(RQ_READ, 8'd255, 32'sd0);
    send(RQ_WRITE, 8'd255, 32'sh12345678);
    send(RQ_WRITE, 8'd1, 32'sh80000000);
    send(RQ_READ, 8'd1, 32'sd0);
    // Removals on a non-empty list, legal and out of range.
    send(RQ_REMOVE_AT, 8'd1, 32'sd0);
    send(RQ_REMOVE_AT, 8'd200, 32'sd0);
    send(RQ_REMOVE_AT, 8'd3, 32'sd0);
    send(RQ_REMOVE_FRONT, 8'd0, 32'sd0);
    send(RQ_REMOVE_BACK, 8'd0, 32'sd0);
    send(RQ_READ, 8'd0, 32'sd0);

    // Random phases: mix, fill to full and beyond, mix, drain to empty.
    step = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (step % 4)
        1: mode = MODE_FILL;
        3: mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      extra = (mode == MODE_MIX) ? $urandom_range(40, 80) : $urandom_range(3, 8);
      while (extra > 0 && random_sent < RANDOM_ITEMS) begin
        pace();
        choose(mode, op, idx, val);
        drive(op, idx, val);
        random_sent++;
        // fill and drain only count down once they hit their limit
        if (mode == MODE_MIX || (mode == MODE_FILL && sb.n == DEPTH) ||
            (mode == MODE_DRAIN && sb.n == 0))
          extra--;
      end
      step++;
    end

    @(negedge clk);
    req.valid = 1'b0;

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d random); peak of %0d entries, %0d list-full,",
             total_sent, random_sent, sb.peak, sb.rejects[ST_FULL]);
    $display("  %0d list-empty and %0d index-range rejections",
             sb.rejects[ST_EMPTY], sb.rejects[ST_RANGE]);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
